// ----- design/phv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phv_pkg
// Shared types and constants for the packet header validator.
// ----------------------------------------------------------------------------
package phv_pkg;

	localparam int LEN_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int SCHEMA_WORDS = 4;
	localparam int ENTRIES_PER_WORD = 4;
	localparam int ENTRY_W    = 16;
	localparam int USED_W     = 5;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// Byte offsets of the captured header fields
	localparam logic [LEN_W-1:0] POS_PROTO_END = 17'd4;
	localparam logic [LEN_W-1:0] POS_SCHEMA_HI = 17'd12;
	localparam logic [LEN_W-1:0] POS_SCHEMA_LO = 17'd13;
	localparam logic [LEN_W-1:0] POS_PAYLD_HI  = 17'd14;
	localparam logic [LEN_W-1:0] POS_PAYLD_LO  = 17'd15;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PROTOCOL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEMA_USED       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEMA_WORD_A     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEMA_WORD_B     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEMA_WORD_C     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEMA_WORD_D     = 3'd5;

	typedef enum logic [2:0] {
		VERDICT_VALID     = 3'd0,
		VERDICT_TRUNCATED = 3'd1,
		VERDICT_PROTOCOL  = 3'd2,
		VERDICT_SCHEMA    = 3'd3,
		VERDICT_MALFORMED = 3'd4
	} phv_verdict_t;

	typedef struct packed {
		logic [31:0]                                    expected_protocol;
		logic [USED_W-1:0]                              entries_used;
		logic [SCHEMA_WORDS-1:0][CFG_DATA_W-1:0]        schema_words;
	} phv_cfg_t;

	// Word passed from the parser to the statistics stage
	typedef struct packed {
		logic         is_clear;
		phv_verdict_t verdict;
		logic [LEN_W-1:0] len;
	} phv_desc_t;

	typedef struct packed {
		phv_verdict_t verdict;
		logic [31:0]  total_packets;
		logic [47:0]  total_bytes;
		logic [31:0]  truncated_count;
		logic [31:0]  protocol_error_count;
		logic [31:0]  unknown_schema_count;
		logic [31:0]  malformed_count;
		logic [31:0]  valid_count;
	} phv_result_t;

endpackage

// ----- design/phv_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phv_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module phv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule

// ----- design/phv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phv_front
// Byte parser: captures header fields, tracks length, classifies on last byte.
// ----------------------------------------------------------------------------
module phv_front
	import phv_pkg::*;
#(
	parameter int MAX_SCHEMA_ENTRIES = 16,
	parameter int MIN_PACKET_BYTES   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  phv_cfg_t  cfg,
	input  logic      acc,
	input  logic      cmd,
	input  logic [7:0] data_byte,
	input  logic      last_byte,
	output logic      desc_push,
	output phv_desc_t desc
);

	logic [LEN_W-1:0] pos_q;
	logic [31:0]      proto_q;
	logic [15:0]      schema_q;
	logic [15:0]      payload_q;

	logic [31:0]      proto_nx;
	logic [15:0]      schema_nx;
	logic [15:0]      payload_nx;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] len_room;
	logic [USED_W-1:0] used;
	logic [MAX_SCHEMA_ENTRIES-1:0] hit;
	logic             schema_ok;
	logic             byte_acc;
	phv_verdict_t     verdict;

	assign byte_acc = acc && !cmd;

	always_comb begin
		proto_nx   = proto_q;
		schema_nx  = schema_q;
		payload_nx = payload_q;
		if (pos_q < POS_PROTO_END) begin
			proto_nx = {proto_q[23:0], data_byte};
		end else if (pos_q == POS_SCHEMA_HI || pos_q == POS_SCHEMA_LO) begin
			schema_nx = {schema_q[7:0], data_byte};
		end else if (pos_q == POS_PAYLD_HI || pos_q == POS_PAYLD_LO) begin
			payload_nx = {payload_q[7:0], data_byte};
		end
	end

	// Saturate the length
	assign len = (pos_q == LEN_MAX) ? LEN_MAX : pos_q + 1'b1;
	assign len_room = len - LEN_W'(MIN_PACKET_BYTES);

	assign used = (cfg.entries_used > USED_W'(MAX_SCHEMA_ENTRIES)) ?
		USED_W'(MAX_SCHEMA_ENTRIES) : cfg.entries_used;

	for (genvar i = 0; i < MAX_SCHEMA_ENTRIES; i++) begin : g_schema
		assign hit[i] = (USED_W'(i) < used) &&
			(cfg.schema_words[i / ENTRIES_PER_WORD]
				[(i % ENTRIES_PER_WORD) * ENTRY_W +: ENTRY_W] == schema_nx);
	end
	assign schema_ok = |hit;

	always_comb begin
		priority if (len < LEN_W'(MIN_PACKET_BYTES)) begin
			verdict = VERDICT_TRUNCATED;
		end else if (proto_nx != cfg.expected_protocol) begin
			verdict = VERDICT_PROTOCOL;
		end else if (!schema_ok) begin
			verdict = VERDICT_SCHEMA;
		end else if ({1'b0, payload_nx} > len_room) begin
			verdict = VERDICT_MALFORMED;
		end else begin
			verdict = VERDICT_VALID;
		end
	end

	assign desc_push     = acc && (cmd || last_byte);
	assign desc.is_clear = cmd;
	assign desc.verdict  = verdict;
	assign desc.len      = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			proto_q   <= '0;
			schema_q  <= '0;
			payload_q <= '0;
		end else if (byte_acc) begin
			if (last_byte) begin
				pos_q     <= '0;
				proto_q   <= '0;
				schema_q  <= '0;
				payload_q <= '0;
			end else begin
				pos_q     <= len;
				proto_q   <= proto_nx;
				schema_q  <= schema_nx;
				payload_q <= payload_nx;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		byte_acc && last_byte |=> pos_q == '0 && proto_q == '0)
		else $error("parser did not restart after last byte");

endmodule

// ----- design/phv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phv_back
// Statistics stage: applies verdicts and clears to the counters, emits results.
// ----------------------------------------------------------------------------
module phv_back
	import phv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        desc_empty,
	input  phv_desc_t   desc,
	output logic        desc_pop,
	input  logic        res_full,
	output logic        res_push,
	output phv_result_t res
);

	logic [31:0] pkts_q, trunc_q, proto_q, schema_q, malf_q, valid_q;
	logic [47:0] bytes_q;
	logic [31:0] pkts_nx, trunc_nx, proto_nx, schema_nx, malf_nx, valid_nx;
	logic [47:0] bytes_nx;

	// Clears need no result slot
	assign desc_pop = !desc_empty && (desc.is_clear || !res_full);
	assign res_push = desc_pop && !desc.is_clear;

	always_comb begin
		pkts_nx   = pkts_q;
		bytes_nx  = bytes_q;
		trunc_nx  = trunc_q;
		proto_nx  = proto_q;
		schema_nx = schema_q;
		malf_nx   = malf_q;
		valid_nx  = valid_q;
		if (desc.is_clear) begin
			pkts_nx   = '0;
			bytes_nx  = '0;
			trunc_nx  = '0;
			proto_nx  = '0;
			schema_nx = '0;
			malf_nx   = '0;
			valid_nx  = '0;
		end else begin
			pkts_nx  = pkts_q + 1'b1;
			bytes_nx = bytes_q + 48'(desc.len);
			unique case (desc.verdict)
				VERDICT_VALID:     valid_nx  = valid_q + 1'b1;
				VERDICT_TRUNCATED: trunc_nx  = trunc_q + 1'b1;
				VERDICT_PROTOCOL:  proto_nx  = proto_q + 1'b1;
				VERDICT_SCHEMA:    schema_nx = schema_q + 1'b1;
				VERDICT_MALFORMED: malf_nx   = malf_q + 1'b1;
				default:           valid_nx  = valid_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkts_q   <= '0;
			bytes_q  <= '0;
			trunc_q  <= '0;
			proto_q  <= '0;
			schema_q <= '0;
			malf_q   <= '0;
			valid_q  <= '0;
		end else if (desc_pop) begin
			pkts_q   <= pkts_nx;
			bytes_q  <= bytes_nx;
			trunc_q  <= trunc_nx;
			proto_q  <= proto_nx;
			schema_q <= schema_nx;
			malf_q   <= malf_nx;
			valid_q  <= valid_nx;
		end
	end

	assign res.verdict              = desc.verdict;
	assign res.total_packets        = pkts_nx;
	assign res.total_bytes          = bytes_nx;
	assign res.truncated_count      = trunc_nx;
	assign res.protocol_error_count = proto_nx;
	assign res.unknown_schema_count = schema_nx;
	assign res.malformed_count      = malf_nx;
	assign res.valid_count          = valid_nx;

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop && desc.is_clear |=> pkts_q == '0 && bytes_q == '0)
		else $error("clear did not zero the counters");

	a_packet_counts: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> pkts_q == $past(pkts_q) + 32'd1)
		else $error("packet counter did not advance");

endmodule

// ----- design/packet_header_validator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_validator_top
// Byte-stream packet header checker with wrapping statistics counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive cmd/data_byte/last_byte and raise push; the
//   word is taken on an edge with push high and full low. One byte per cycle
//   is sustained while full stays low. cmd high is a counter clear that
//   yields no result. Result side is a queue: while empty is low the oldest
//   verdict and the counters after that packet sit on the result ports; pop
//   takes it. A verdict passes the middle queue, then the result queue, to
//   reach the result ports. The parser feeds a two-entry queue
//   into the statistics stage, which fills a two-entry result queue; one word
//   per cycle flows while pop keeps up.
//   When the receiver stalls, the result queue fills, then the middle queue,
//   and full rises; clears still drain past a stalled result side.
//   Config writes go over cfg_valid/cfg_ready (ready is always high). The user
//   makes them only while the block is idle; the block does not enforce this.
//   Reset clears all counters, captures and config registers; input is taken right after reset.
// ----------------------------------------------------------------------------
module packet_header_validator_top
	import phv_pkg::*;
#(
	parameter int MAX_SCHEMA_ENTRIES = 16,
	parameter int MIN_PACKET_BYTES   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  cmd,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            verdict,
	output logic [31:0]           total_packets,
	output logic [47:0]           total_bytes,
	output logic [31:0]           truncated_count,
	output logic [31:0]           protocol_error_count,
	output logic [31:0]           unknown_schema_count,
	output logic [31:0]           malformed_count,
	output logic [31:0]           valid_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int QUEUE_DEPTH = 2;

	phv_cfg_t    cfg_q;
	logic        acc;
	logic        desc_push, desc_full, desc_empty, desc_pop;
	phv_desc_t   desc_in, desc_out;
	logic        res_push, res_full;
	phv_result_t res_in, res_out;
	logic [$bits(phv_desc_t)-1:0]   desc_bits;
	logic [$bits(phv_result_t)-1:0] res_bits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXPECTED_PROTOCOL: cfg_q.expected_protocol <= cfg_data[31:0];
				REG_SCHEMA_USED:       cfg_q.entries_used <= cfg_data[USED_W-1:0];
				REG_SCHEMA_WORD_A:     cfg_q.schema_words[0] <= cfg_data;
				REG_SCHEMA_WORD_B:     cfg_q.schema_words[1] <= cfg_data;
				REG_SCHEMA_WORD_C:     cfg_q.schema_words[2] <= cfg_data;
				REG_SCHEMA_WORD_D:     cfg_q.schema_words[3] <= cfg_data;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	assign full = desc_full;
	assign acc  = push && !full;

	phv_front #(
		.MAX_SCHEMA_ENTRIES (MAX_SCHEMA_ENTRIES),
		.MIN_PACKET_BYTES   (MIN_PACKET_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.acc       (acc),
		.cmd       (cmd),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.desc_push (desc_push),
		.desc      (desc_in)
	);

	phv_fifo #(
		.WIDTH ($bits(phv_desc_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_desc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (desc_push),
		.wdata  (desc_in),
		.full   (desc_full),
		.pop    (desc_pop),
		.rdata  (desc_bits),
		.empty  (desc_empty)
	);

	assign desc_out = phv_desc_t'(desc_bits);

	phv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_empty (desc_empty),
		.desc       (desc_out),
		.desc_pop   (desc_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	phv_fifo #(
		.WIDTH ($bits(phv_result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_bits),
		.empty  (empty)
	);

	assign res_out              = phv_result_t'(res_bits);
	assign verdict              = res_out.verdict;
	assign total_packets        = res_out.total_packets;
	assign total_bytes          = res_out.total_bytes;
	assign truncated_count      = res_out.truncated_count;
	assign protocol_error_count = res_out.protocol_error_count;
	assign unknown_schema_count = res_out.unknown_schema_count;
	assign malformed_count      = res_out.malformed_count;
	assign valid_count          = res_out.valid_count;

endmodule
